>>> sv/lrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants for the lyric timestamp line parser.
// ----------------------------------------------------------------------------
package lrc_pkg;

    // configuration register indexes
    localparam logic CFG_LINE_LIMIT = 1'b0;
    localparam logic CFG_TEXT_LIMIT = 1'b1;

    localparam logic [7:0] LINE_LIMIT_RESET = 8'd128;
    localparam logic [7:0] TEXT_LIMIT_RESET = 8'd63;

    // record kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;

    localparam logic [31:0] MS_PER_MIN = 32'd60000;
    localparam logic [31:0] MS_PER_SEC = 32'd1000;

    // records one character can cause, and the output queue sizing
    localparam int MAX_RECS    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_MIN,
        PH_SEC,
        PH_FRAC,
        PH_TEXT
    } lrc_phase_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] time_ms;
        logic [7:0]  text_byte;
        logic [7:0]  line_number;
        logic        final_of_item;
    } lrc_rec_t;

    typedef struct packed {
        logic [1:0]                  count;
        lrc_rec_t [MAX_RECS-1:0]     recs;
    } lrc_group_t;

    typedef struct packed {
        lrc_phase_t  phase;
        logic [7:0]  line_count;
    } lrc_status_t;

endpackage

>>> sv/lrc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_ifs
// Valid/ready channels for input characters and output records.
// ----------------------------------------------------------------------------
interface lrc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       block_end;

    modport source (output valid, output char_byte, output block_end, input ready);
    modport sink   (input valid, input char_byte, input block_end, output ready);
endinterface

interface lrc_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [31:0] time_ms;
    logic [7:0]  text_byte;
    logic [7:0]  line_number;
    logic        final_of_item;

    modport source (output valid, output record_kind, output time_ms, output text_byte,
                    output line_number, output final_of_item, input ready);
    modport sink   (input valid, input record_kind, input time_ms, input text_byte,
                    input line_number, input final_of_item, output ready);
endinterface

>>> sv/lrc_timestamp_line_parser_top.sv
`timescale 1ns / 1ps
// output: records of an accepted character are registered in the queue, behind older ones
// throughput: one character per cycle while each makes at most one record and the sink
// takes one every cycle; input stalls while the 4-entry record queue holds over one record
// reset: parser state, line count and queue cleared; line_limit 128, text_limit 63
// ----------------------------------------------------------------------------
// lrc_timestamp_line_parser_top
// Parses [mm:ss.ff]text lyric lines into line start, text and line end records.
// ----------------------------------------------------------------------------
module lrc_timestamp_line_parser_top import lrc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data,
    lrc_char_if.sink     char_in,
    lrc_rec_if.source    rec_out
);

    logic [7:0]        line_limit_reg;
    logic [7:0]        text_limit_reg;
    logic              accept;
    logic              pop;
    logic [QCNT_W-1:0] q_count;
    lrc_group_t        group;
    lrc_status_t       status;
    lrc_rec_t          head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= LINE_LIMIT_RESET;
            text_limit_reg <= TEXT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_LIMIT: line_limit_reg <= cfg_data;
                CFG_TEXT_LIMIT: text_limit_reg <= cfg_data;
                default:        line_limit_reg <= line_limit_reg;
            endcase
        end
    end

    // room for a full group even if nothing drains this cycle
    assign char_in.ready = (q_count <= QCNT_W'(QUEUE_DEPTH - MAX_RECS));
    assign accept        = char_in.valid && char_in.ready;
    assign pop           = rec_out.valid && rec_out.ready;

    lrc_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_byte  (char_in.char_byte),
        .block_end  (char_in.block_end),
        .line_limit (line_limit_reg),
        .text_limit (text_limit_reg),
        .group      (group),
        .status     (status)
    );

    lrc_rec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_group (group),
        .pop        (pop),
        .count      (q_count),
        .head       (head)
    );

    assign rec_out.valid         = (q_count != '0);
    assign rec_out.record_kind   = head.record_kind;
    assign rec_out.time_ms       = head.time_ms;
    assign rec_out.text_byte     = head.text_byte;
    assign rec_out.line_number   = head.line_number;
    assign rec_out.final_of_item = head.final_of_item;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("record queue overfilled");

    a_block_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_in.block_end) |=> (status.phase == PH_IDLE && status.line_count == 8'd0))
        else $error("parser not reset after block end");

    a_time_only_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_out.valid && rec_out.record_kind != KIND_START) |-> (rec_out.time_ms == 32'd0))
        else $error("timestamp on a non-start record");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rec_out.valid |-> (rec_out.record_kind != 2'd3))
        else $error("illegal record kind");

endmodule

>>> sv/lrc_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_parse_core
// Parser state and per-character decode into up to three records.
// ----------------------------------------------------------------------------
module lrc_parse_core import lrc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  char_byte,
    input  logic        block_end,
    input  logic [7:0]  line_limit,
    input  logic [7:0]  text_limit,
    output lrc_group_t  group,
    output lrc_status_t status
);

    lrc_phase_t  phase_reg, phase_next;
    logic [15:0] minutes_reg, minutes_next;
    logic [15:0] seconds_reg, seconds_next;
    logic [6:0]  frac_reg, frac_next;
    logic [1:0]  frac_digits_reg, frac_digits_next;
    logic [7:0]  text_count_reg, text_count_next;
    logic [7:0]  line_count_reg, line_count_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic        active;
    logic        flush;
    logic        close_stamp;
    logic        do_text;
    logic        emit_start;
    logic        emit_text;
    logic        emit_end;
    logic [19:0] min_mul;
    logic [19:0] sec_mul;
    logic [9:0]  frac_ms;
    logic [31:0] start_ms;
    lrc_rec_t    rec_start;
    lrc_rec_t    rec_text;
    lrc_rec_t    rec_end;
    logic [1:0]  slot;

    assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign digit    = 4'(char_byte - CH_ZERO);
    assign active   = (char_byte != CH_NUL) && (line_count_reg < line_limit);
    assign flush    = (char_byte == CH_NUL) || block_end;
    assign min_mul  = 20'(minutes_reg) * 20'd10 + 20'(digit);
    assign sec_mul  = 20'(seconds_reg) * 20'd10 + 20'(digit);

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        minutes_next     = minutes_reg;
        seconds_next     = seconds_reg;
        frac_next        = frac_reg;
        frac_digits_next = frac_digits_reg;
        text_count_next  = text_count_reg;
        line_count_next  = line_count_reg;
        close_stamp      = 1'b0;
        do_text          = 1'b0;
        emit_start       = 1'b0;
        emit_text        = 1'b0;
        emit_end         = 1'b0;

        if (active)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (char_byte == CH_LF || char_byte == CH_CR ||
                        char_byte == CH_SPACE || char_byte == CH_TAB)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (char_byte == CH_LBRK)
                    begin
                        minutes_next     = '0;
                        seconds_next     = '0;
                        frac_next        = '0;
                        frac_digits_next = '0;
                        phase_next       = PH_MIN;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (char_byte == CH_LF)
                        phase_next = PH_IDLE;
                end
                PH_MIN:
                begin
                    if (is_digit)
                        minutes_next = (min_mul > 20'd65535) ? 16'hFFFF : min_mul[15:0];
                    else if (char_byte == CH_COLON)
                        phase_next = PH_SEC;
                    else if (char_byte == CH_DOT)
                        phase_next = PH_FRAC;
                    else
                        close_stamp = 1'b1;
                end
                PH_SEC:
                begin
                    if (is_digit)
                        seconds_next = (sec_mul > 20'd65535) ? 16'hFFFF : sec_mul[15:0];
                    else if (char_byte == CH_DOT)
                        phase_next = PH_FRAC;
                    else
                        close_stamp = 1'b1;
                end
                PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        if (frac_digits_reg < 2'd2)
                        begin
                            frac_next        = 7'(frac_reg * 7'd10 + 7'(digit));
                            frac_digits_next = frac_digits_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        close_stamp = 1'b1;
                    end
                end
                PH_TEXT:
                begin
                    do_text = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (close_stamp)
            begin
                emit_start      = 1'b1;
                text_count_next = '0;
                phase_next      = PH_TEXT;
                do_text         = (char_byte != CH_RBRK);
            end

            if (do_text)
            begin
                if (char_byte == CH_LF)
                begin
                    emit_end   = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (char_byte == CH_CR)
                begin
                    emit_end   = 1'b1;
                    phase_next = PH_SKIP;
                end
                else if (text_count_next < text_limit)
                begin
                    emit_text       = 1'b1;
                    text_count_next = text_count_next + 8'd1;
                end
            end

            if (emit_end)
                line_count_next = line_count_reg + 8'd1;
        end

        // end of block or a zero byte closes whatever line is still open
        if (flush)
        begin
            if (phase_next == PH_MIN || phase_next == PH_SEC || phase_next == PH_FRAC)
            begin
                emit_start = 1'b1;
                emit_end   = 1'b1;
            end
            else if (phase_next == PH_TEXT)
            begin
                emit_end = 1'b1;
            end
        end
    end

    // timestamp from the accumulators as they stand after this character
    always_comb
    begin
        case (frac_digits_next)
            2'd1:    frac_ms = 10'(frac_next) * 10'd100;
            2'd2:    frac_ms = 10'(frac_next) * 10'd10;
            default: frac_ms = '0;
        endcase
        start_ms = 32'(minutes_next) * MS_PER_MIN + 32'(seconds_next) * MS_PER_SEC
                 + 32'(frac_ms);
    end

    // outputs: records in the order start, text, end
    always_comb
    begin
        rec_start = '{record_kind: KIND_START, time_ms: start_ms, text_byte: 8'd0,
                      line_number: line_count_reg, final_of_item: 1'b0};
        rec_text  = '{record_kind: KIND_TEXT, time_ms: 32'd0, text_byte: char_byte,
                      line_number: line_count_reg, final_of_item: 1'b0};
        rec_end   = '{record_kind: KIND_END, time_ms: 32'd0, text_byte: 8'd0,
                      line_number: line_count_reg, final_of_item: 1'b0};
        group = '0;
        slot  = 2'd0;
        if (emit_start)
        begin
            group.recs[slot] = rec_start;
            slot = slot + 2'd1;
        end
        if (emit_text)
        begin
            group.recs[slot] = rec_text;
            slot = slot + 2'd1;
        end
        if (emit_end)
        begin
            group.recs[slot] = rec_end;
            slot = slot + 2'd1;
        end
        group.count = slot;
        if (slot != 2'd0)
            group.recs[slot - 2'd1].final_of_item = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            minutes_reg     <= '0;
            seconds_reg     <= '0;
            frac_reg        <= '0;
            frac_digits_reg <= '0;
            text_count_reg  <= '0;
            line_count_reg  <= '0;
        end
        else if (accept)
        begin
            if (flush)
            begin
                phase_reg       <= PH_IDLE;
                minutes_reg     <= '0;
                seconds_reg     <= '0;
                frac_reg        <= '0;
                frac_digits_reg <= '0;
                text_count_reg  <= '0;
                line_count_reg  <= '0;
            end
            else
            begin
                phase_reg       <= phase_next;
                minutes_reg     <= minutes_next;
                seconds_reg     <= seconds_next;
                frac_reg        <= frac_next;
                frac_digits_reg <= frac_digits_next;
                text_count_reg  <= text_count_next;
                line_count_reg  <= line_count_next;
            end
        end
    end

    assign status = '{phase: phase_reg, line_count: line_count_reg};

endmodule

>>> sv/lrc_rec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_rec_queue
// Shifting record queue: takes up to three records a beat, gives one.
// ----------------------------------------------------------------------------
module lrc_rec_queue import lrc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lrc_group_t        push_group,
    input  logic              pop,
    output logic [QCNT_W-1:0] count,
    output lrc_rec_t          head
);

    lrc_rec_t          entry_reg  [QUEUE_DEPTH];
    lrc_rec_t          entry_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QCNT_W-1:0] base;
    logic [1:0]        push_cnt;

    always_comb
    begin
        push_cnt   = push ? push_group.count : 2'd0;
        base       = count_reg - QCNT_W'(pop);
        count_next = base + QCNT_W'(push_cnt);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            entry_next[i] = (pop && (i < QUEUE_DEPTH - 1))
                          ? entry_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i] : entry_reg[i];
            // new records land right behind the surviving ones
            if ((QCNT_W'(i) >= base) && (QCNT_W'(i) - base < QCNT_W'(push_cnt)))
                entry_next[i] = push_group.recs[2'(QCNT_W'(i) - base)];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            entry_reg[i] <= entry_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign count = count_reg;
    assign head  = entry_reg[0];

endmodule

>>> tb/lrc_timestamp_line_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_timestamp_line_parser_checker
// Watches the character and record channels and the register port, predicts
// the records of every accepted character and compares them in order.
// ----------------------------------------------------------------------------
module lrc_timestamp_line_parser_checker import lrc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    lrc_char_if        char_mon,
    lrc_rec_if         rec_mon,
    output int         fail_count,
    output int         pending_recs
);

    localparam int REPORT_MAX = 10;

    // predicted parser state and register copies
    lrc_phase_t  cur_phase;
    logic [15:0] min_val;
    logic [15:0] sec_val;
    logic [6:0]  frac_val;
    logic [1:0]  frac_len;
    logic [7:0]  kept_text;
    logic [7:0]  lines_done;
    logic [7:0]  max_lines;
    logic [7:0]  max_text;

    lrc_rec_t step_recs[$];
    lrc_rec_t expected_recs[$];

    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
        int unsigned v;
        v = acc * 10 + d;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [31:0] stamp_ms();
        logic [31:0] frac_ms;
        frac_ms = 32'd0;
        if (frac_len == 2'd1)
            frac_ms = 32'(frac_val) * 32'd100;
        else if (frac_len >= 2'd2)
            frac_ms = 32'(frac_val) * 32'd10;
        return 32'(min_val) * MS_PER_MIN + 32'(sec_val) * MS_PER_SEC + frac_ms;
    endfunction

    task automatic add_rec(input logic [1:0] kind, input logic [31:0] ms, input logic [7:0] b);
        if (step_recs.size() < MAX_RECS)
            step_recs.push_back('{record_kind: kind, time_ms: ms, text_byte: b,
                                  line_number: lines_done, final_of_item: 1'b0});
    endtask

    task automatic close_line();
        add_rec(KIND_END, 32'd0, 8'd0);
        lines_done = lines_done + 8'd1;
    endtask

    task automatic take_text(input logic [7:0] c);
        if (c == CH_LF)
        begin
            close_line();
            cur_phase = PH_IDLE;
        end
        else if (c == CH_CR)
        begin
            // carriage return ends the line, rest dropped up to newline
            close_line();
            cur_phase = PH_SKIP;
        end
        else if (kept_text < max_text)
        begin
            add_rec(KIND_TEXT, 32'd0, c);
            kept_text = kept_text + 8'd1;
        end
    endtask

    // timestamp closed: start record, then the closing char is text unless ']'
    task automatic open_text(input logic [7:0] c);
        add_rec(KIND_START, stamp_ms(), 8'd0);
        kept_text = 8'd0;
        cur_phase = PH_TEXT;
        if (c != CH_RBRK)
            take_text(c);
    endtask

    task automatic clear_parse();
        cur_phase  = PH_IDLE;
        min_val    = '0;
        sec_val    = '0;
        frac_val   = '0;
        frac_len   = '0;
        kept_text  = '0;
        lines_done = '0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic is_last);
        logic       digit;
        logic [3:0] d;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d     = 4'(c - CH_ZERO);
        step_recs.delete();
        if (c != CH_NUL && lines_done < max_lines)
        begin
            case (cur_phase)
                PH_IDLE:
                begin
                    if (c == CH_LBRK)
                    begin
                        min_val   = '0;
                        sec_val   = '0;
                        frac_val  = '0;
                        frac_len  = '0;
                        cur_phase = PH_MIN;
                    end
                    else if (c != CH_LF && c != CH_CR && c != CH_SPACE && c != CH_TAB)
                        cur_phase = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (c == CH_LF)
                        cur_phase = PH_IDLE;
                end
                PH_MIN:
                begin
                    if (digit)
                        min_val = add_digit(min_val, d);
                    else if (c == CH_COLON)
                        cur_phase = PH_SEC;
                    else if (c == CH_DOT)
                        cur_phase = PH_FRAC;
                    else
                        open_text(c);
                end
                PH_SEC:
                begin
                    if (digit)
                        sec_val = add_digit(sec_val, d);
                    else if (c == CH_DOT)
                        cur_phase = PH_FRAC;
                    else
                        open_text(c);
                end
                PH_FRAC:
                begin
                    if (digit)
                    begin
                        // digits past the second are consumed
                        if (frac_len < 2'd2)
                        begin
                            frac_val = 7'(frac_val * 10 + d);
                            frac_len = frac_len + 2'd1;
                        end
                    end
                    else
                        open_text(c);
                end
                PH_TEXT:
                    take_text(c);
                default:
                    cur_phase = PH_IDLE;
            endcase
        end
        if (c == CH_NUL || is_last)
        begin
            if (cur_phase == PH_MIN || cur_phase == PH_SEC || cur_phase == PH_FRAC)
            begin
                add_rec(KIND_START, stamp_ms(), 8'd0);
                close_line();
            end
            else if (cur_phase == PH_TEXT)
                close_line();
            clear_parse();
        end
        if (step_recs.size() > 0)
            step_recs[step_recs.size() - 1].final_of_item = 1'b1;
        foreach (step_recs[i])
            expected_recs.push_back(step_recs[i]);
    endtask

    task automatic report_fail(input string what, input lrc_rec_t want, input lrc_rec_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t %s: expected kind %0d ms %0d byte %02h line %0d final %0b, got kind %0d ms %0d byte %02h line %0d final %0b",
                     $realtime, what, want.record_kind, want.time_ms, want.text_byte,
                     want.line_number, want.final_of_item, got.record_kind, got.time_ms,
                     got.text_byte, got.line_number, got.final_of_item);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lrc_rec_t got;
        if (!rst_n)
        begin
            clear_parse();
            max_lines = LINE_LIMIT_RESET;
            max_text  = TEXT_LIMIT_RESET;
            expected_recs.delete();
            fail_count   = 0;
            pending_recs <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_LINE_LIMIT)
                    max_lines = cfg_data;
                else
                    max_text = cfg_data;
            end
            if (char_mon.valid && char_mon.ready)
                parse_char(char_mon.char_byte, char_mon.block_end);
            if (rec_mon.valid && rec_mon.ready)
            begin
                got = '{record_kind: rec_mon.record_kind, time_ms: rec_mon.time_ms,
                        text_byte: rec_mon.text_byte, line_number: rec_mon.line_number,
                        final_of_item: rec_mon.final_of_item};
                if (expected_recs.size() == 0)
                    report_fail("unexpected record", '0, got);
                else if (got !== expected_recs[0])
                    report_fail("record mismatch", expected_recs.pop_front(), got);
                else
                    void'(expected_recs.pop_front());
            end
            pending_recs <= expected_recs.size();
        end
    end

endmodule

>>> tb/lrc_timestamp_line_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_timestamp_line_parser_top_tb
// Feeds lyric text, directed then random lines, through the parser under
// several limit settings with random gaps and stalls on both channels; the
// checker predicts and compares every record.
// ----------------------------------------------------------------------------
module lrc_timestamp_line_parser_top_tb;
    import lrc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD = 300;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    int  fail_count;
    int  pending_recs;
    int  chars_sent = 0;
    int  cycle_cnt = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    bit  hold_rx = 1'b0;

    logic [7:0] line_buf[$];

    lrc_char_if char_ch();
    lrc_rec_if  rec_ch();

    lrc_timestamp_line_parser_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .char_in   (char_ch),
        .rec_out   (rec_ch)
    );

    lrc_timestamp_line_parser_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_mon     (char_ch),
        .rec_mon      (rec_ch),
        .fail_count   (fail_count),
        .pending_recs (pending_recs)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // record sink: random stall per beat, one long hold-off on request
    initial
    begin
        int gap;
        rec_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 17) : 0;
            if (hold_rx)
            begin
                hold_rx = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                rec_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rec_ch.ready <= 1'b1;
            do @(posedge clk); while (!rec_ch.valid);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_byte <= c;
        char_ch.block_end <= is_last;
        do @(posedge clk); while (!char_ch.ready);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic end_block);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_block && (i == s.len() - 1));
    endtask

    // drain all records, then give the block time to finish a silent character
    task automatic settle();
        char_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_recs != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [7:0] lines, input logic [7:0] text);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LINE_LIMIT;
        cfg_data  <= lines;
        @(posedge clk);
        cfg_index <= CFG_TEXT_LIMIT;
        cfg_data  <= text;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int digit_count();
        return ($urandom_range(0, 7) == 0) ? 6 : $urandom_range(0, 3);
    endfunction

    task automatic add_digits(input int n);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_printable();
        line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    // mostly well-formed lines with random content, some noise
    task automatic send_random_line();
        int  n;
        int  r;
        bit  end_block;
        line_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 3) == 0)
                line_buf.push_back(CH_NUL);
        end
        else
        begin
            repeat ($urandom_range(0, 2))
            begin
                case ($urandom_range(0, 3))
                    0: line_buf.push_back(CH_SPACE);
                    1: line_buf.push_back(CH_TAB);
                    2: line_buf.push_back(CH_LF);
                    default: line_buf.push_back(CH_CR);
                endcase
            end
            line_buf.push_back(CH_LBRK);
            add_digits(digit_count());
            r = $urandom_range(0, 7);
            if (r == 1)
                line_buf.push_back(CH_DOT);
            else if (r > 1)
                line_buf.push_back(CH_COLON);
            add_digits(digit_count());
            if ($urandom_range(0, 3) != 0)
            begin
                line_buf.push_back(CH_DOT);
                add_digits($urandom_range(0, 3));
            end
            if ($urandom_range(0, 5) != 0)
                line_buf.push_back(CH_RBRK);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                if ($urandom_range(0, 7) == 0)
                    line_buf.push_back(8'($urandom_range(1, 255)));
                else
                    add_printable();
            end
            r = $urandom_range(0, 7);
            if (r < 5)
                line_buf.push_back(CH_LF);
            else if (r == 5)
            begin
                line_buf.push_back(CH_CR);
                if ($urandom_range(0, 1) == 1)
                    add_printable();
                line_buf.push_back(CH_LF);
            end
        end
        end_block = ($urandom_range(0, 4) == 0);
        foreach (line_buf[i])
            send_char(line_buf[i], end_block && (i == line_buf.size() - 1));
    endtask

    task automatic run_random(input int upto);
        while (chars_sent < upto)
            send_random_line();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_LINE_LIMIT;
        cfg_data          <= 8'd0;
        char_ch.valid     <= 1'b0;
        char_ch.char_byte <= 8'd0;
        char_ch.block_end <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whitespace skip, minute saturation, long fraction, cr in text
        send_text("\t [70000:1.123]x\rq\n", 1'b0);
        // dropped line, then missing colon with tenths, flushed by block end
        send_text("z\n[5.7x", 1'b1);
        // open timestamp flushed by a zero byte
        send_text("[3", 1'b0);
        send_char(CH_NUL, 1'b0);

        run_random(chars_sent + 30);

        set_limits(8'd1, 8'd0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_random(chars_sent + 28);

        // long sink hold-off while characters keep coming
        set_limits(8'd255, 8'd255);
        rx_idle = 1'b1;
        hold_rx = 1'b1;
        run_random(chars_sent + 30);

        set_limits(8'd2, 8'd3);
        tx_idle = 1'b1;
        run_random(chars_sent + 30);

        set_limits(8'($urandom_range(1, 8)), 8'($urandom_range(0, 12)));
        tx_idle = 1'($urandom_range(0, 1));
        run_random(chars_sent + 28);

        settle();
        if (fail_count == 0 && pending_recs == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/lrc_pkg.sv
sv/lrc_ifs.sv
sv/lrc_parse_core.sv
sv/lrc_rec_queue.sv
sv/lrc_timestamp_line_parser_top.sv
tb/lrc_timestamp_line_parser_checker.sv
tb/lrc_timestamp_line_parser_top_tb.sv
